// ===== hdl/kts_pkg.sv =====
// keyframe track sampler: shared types, widths and register codes
// no dependencies; used by the top level and kts_mul

package kts_pkg;

   localparam int MAX_FRAMES_DEF = 1024;

   // field widths
   localparam int COMP_W  = 32;
   localparam int SLOT_W  = 10;
   localparam int TIME_W  = 32;
   localparam int COUNT_W = 11;
   localparam int RATE_W  = 26;
   localparam int FRAC_W  = 16;
   localparam int LANES   = 4;
   localparam int KEY_W   = COMP_W * LANES;

   // phase: time * rate has 32 fraction bits and RATE_W integer bits
   localparam int PHASE_FRAC_W = 32;
   localparam int PHASE_INT_W  = TIME_W + RATE_W - PHASE_FRAC_W;
   localparam int DIV_CNT_W    = $clog2(PHASE_INT_W);

   // shared multiplier operand widths (signed)
   localparam int MUL_A_W = COMP_W + 1;
   localparam int MUL_B_W = RATE_W + 1;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // csr port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = RATE_W;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_RATE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP_ENABLE = 2'd2;

   localparam logic [COUNT_W-1:0] FRAME_COUNT_RST = 11'd1;
   localparam logic [RATE_W-1:0]  FRAME_RATE_RST  = 26'd1966080;
   localparam logic               WRAP_ENABLE_RST = 1'b1;

   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   typedef struct packed {
      logic                     mode;
      logic [SLOT_W-1:0]        frame_slot;
      logic signed [COMP_W-1:0] comp_x;
      logic signed [COMP_W-1:0] comp_y;
      logic signed [COMP_W-1:0] comp_z;
      logic signed [COMP_W-1:0] comp_w;
      logic [TIME_W-1:0]        sample_time;
   } req_type;

   typedef struct packed {
      logic signed [COMP_W-1:0] value_x;
      logic signed [COMP_W-1:0] value_y;
      logic signed [COMP_W-1:0] value_z;
      logic signed [COMP_W-1:0] value_w;
      logic [SLOT_W-1:0]        base_frame;
      logic [FRAC_W-1:0]        blend_fraction;
   } rsp_type;

endpackage

// ===== hdl/keyframe_track_sampler.sv =====
// keyframe track sampler: top level with sequencer, keyframe ram and shared multiplier
// depends on kts_pkg, kts_ram, kts_mul
// a sample request passes, after accept, through a multiply, a load, one restoring divide
//   step per integer phase bit for the frame-count modulo, two ram reads, a diff/multiply/add
//   for each of the four lanes and the output register; the divide loop is the longest part
// a new request is stalled until the sequencer is back in idle, which takes longer while a
//   held response keeps the sequencer waiting; load requests are taken only in idle
// reset clears the sequencer, output valid and csr registers; keyframe ram is not cleared

module keyframe_track_sampler #(
   parameter int MAX_FRAMES = kts_pkg::MAX_FRAMES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  kts_pkg::req_type                  req_data,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output kts_pkg::rsp_type                  rsp_data,
   // csr write port
   input  logic                              csr_wr_en,
   input  logic [kts_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [kts_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int AW = $clog2(MAX_FRAMES);
   localparam int CW = kts_pkg::COUNT_W;
   localparam int CMP_W = 32;

   typedef enum logic [10:0] {
      S_IDLE = 11'b000_0000_0001,
      S_MUL  = 11'b000_0000_0010,
      S_LOAD = 11'b000_0000_0100,
      S_DIV  = 11'b000_0000_1000,
      S_RDA  = 11'b000_0001_0000,
      S_RDB  = 11'b000_0010_0000,
      S_RDW  = 11'b000_0100_0000,
      S_DIFF = 11'b000_1000_0000,
      S_MULT = 11'b001_0000_0000,
      S_ADD  = 11'b010_0000_0000,
      S_DONE = 11'b100_0000_0000
   } state_type;

   // csr registers
   logic [CW-1:0]                  frame_count_ff, frame_count_in;
   logic [kts_pkg::RATE_W-1:0]     frame_rate_ff, frame_rate_in;
   logic                           wrap_enable_ff, wrap_enable_in;

   // sequencer state
   state_type                      state_ff, state_in;
   logic [kts_pkg::TIME_W-1:0]     time_ff, time_in;
   logic [CW-1:0]                  cnt_ff, cnt_in;
   logic                           wrap_ff, wrap_in;
   logic [kts_pkg::PHASE_INT_W-1:0] dvd_ff, dvd_in;
   logic [CW-1:0]                  rem_ff, rem_in;
   logic [kts_pkg::DIV_CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic [kts_pkg::FRAC_W-1:0]     frac_ff, frac_in;
   logic [CW-1:0]                  next_ff, next_in;
   logic [kts_pkg::KEY_W-1:0]      a_ff, a_in;
   logic [kts_pkg::KEY_W-1:0]      b_ff, b_in;
   logic [kts_pkg::KEY_W-1:0]      res_ff, res_in;
   logic signed [kts_pkg::MUL_A_W-1:0] diff_ff, diff_in;
   logic [1:0]                     lane_ff, lane_in;

   // output register
   logic                           rsp_valid_ff, rsp_valid_in;
   kts_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   // datapath helpers
   logic                           req_accept;
   logic [CW-1:0]                  cnt_clamped;
   logic [CW:0]                    rem_shift;
   logic [CW:0]                    base_inc;
   logic                           out_free;
   logic signed [kts_pkg::MUL_A_W-1:0] mul_a;
   logic signed [kts_pkg::MUL_B_W-1:0] mul_b;
   logic signed [kts_pkg::MUL_P_W-1:0] mul_p;
   logic [kts_pkg::COMP_W-1:0]     lerp_val;

   // keyframe ram
   logic                           ram_wr_en;
   logic [AW-1:0]                  ram_wr_addr;
   logic [kts_pkg::KEY_W-1:0]      ram_wr_data;
   logic [AW-1:0]                  ram_rd_addr;
   logic [kts_pkg::KEY_W-1:0]      ram_rd_data;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // load requests write straight into the ram; out-of-range slots dropped
   assign ram_wr_en   = req_accept && (req_data.mode == kts_pkg::MODE_LOAD) &&
                        (CMP_W'(req_data.frame_slot) < CMP_W'(MAX_FRAMES));
   assign ram_wr_addr = AW'(req_data.frame_slot);
   assign ram_wr_data = {req_data.comp_w, req_data.comp_z,
                         req_data.comp_y, req_data.comp_x};
   // base frame first, then next frame
   assign ram_rd_addr = (state_ff == S_RDB) ? AW'(next_ff) : AW'(rem_ff);

   kts_ram #(
      .WIDTH (kts_pkg::KEY_W),
      .DEPTH (MAX_FRAMES)
   ) u_ram (
      .clock      (clock),
      .wr_en      (ram_wr_en),
      .wr_addr    (ram_wr_addr),
      .wr_data    (ram_wr_data),
      .rd_addr    (ram_rd_addr),
      .rd_data_ff (ram_rd_data)
   );

   // multiplier is time*rate in S_MUL, lane diff*fraction in S_MULT
   always_comb begin
      if (state_ff == S_MUL) begin
         mul_a = {1'b0, time_ff};
         mul_b = {1'b0, frame_rate_ff};
      end else begin
         mul_a = diff_ff;
         mul_b = {{(kts_pkg::MUL_B_W - kts_pkg::FRAC_W){1'b0}}, frac_ff};
      end
   end

   kts_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (mul_p)
   );

   // a + floor(diff*frac / 2^16), low 32 bits of the product shift are enough
   assign lerp_val = a_ff[kts_pkg::COMP_W-1:0] +
                     mul_p[kts_pkg::FRAC_W +: kts_pkg::COMP_W];

   // frame count: zero acts as one, saturates at the ram depth
   always_comb begin
      if (frame_count_ff == '0) begin
         cnt_clamped = CW'(1);
      end else if (CMP_W'(frame_count_ff) > CMP_W'(MAX_FRAMES)) begin
         cnt_clamped = CW'(MAX_FRAMES);
      end else begin
         cnt_clamped = frame_count_ff;
      end
   end

   // one restoring divide step: shift in the next phase bit
   assign rem_shift = {rem_ff, dvd_ff[kts_pkg::PHASE_INT_W-1]};
   assign base_inc  = {1'b0, rem_ff} + (CW+1)'(1);

   // csr writes, unknown index ignored
   always_comb begin
      frame_count_in = frame_count_ff;
      frame_rate_in  = frame_rate_ff;
      wrap_enable_in = wrap_enable_ff;
      if (csr_wr_en) begin
         case (csr_index)
            kts_pkg::CSR_FRAME_COUNT: frame_count_in = csr_wdata[CW-1:0];
            kts_pkg::CSR_FRAME_RATE:  frame_rate_in  = csr_wdata;
            kts_pkg::CSR_WRAP_ENABLE: wrap_enable_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      time_in      = time_ff;
      cnt_in       = cnt_ff;
      wrap_in      = wrap_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      frac_in      = frac_ff;
      next_in      = next_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      res_in       = res_ff;
      diff_in      = diff_ff;
      lane_in      = lane_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         S_IDLE: begin
            if (req_accept && (req_data.mode == kts_pkg::MODE_SAMPLE)) begin
               time_in  = req_data.sample_time;
               cnt_in   = cnt_clamped;
               wrap_in  = wrap_enable_ff;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            // integer part goes to the divider, top 16 fraction bits kept
            dvd_in     = mul_p[kts_pkg::PHASE_FRAC_W +: kts_pkg::PHASE_INT_W];
            frac_in    = mul_p[kts_pkg::PHASE_FRAC_W-1 -: kts_pkg::FRAC_W];
            rem_in     = '0;
            div_cnt_in = kts_pkg::DIV_CNT_W'(kts_pkg::PHASE_INT_W - 1);
            state_in   = S_DIV;
         end
         S_DIV: begin
            // remainder stays below count, so the compare needs one extra bit
            if (rem_shift >= {1'b0, cnt_ff}) begin
               rem_in = CW'(rem_shift - {1'b0, cnt_ff});
            end else begin
               rem_in = CW'(rem_shift);
            end
            dvd_in     = {dvd_ff[kts_pkg::PHASE_INT_W-2:0], 1'b0};
            div_cnt_in = div_cnt_ff - kts_pkg::DIV_CNT_W'(1);
            if (div_cnt_ff == '0) begin
               state_in = S_RDA;
            end
         end
         S_RDA: begin
            // next frame wraps to zero or holds the last frame
            if (base_inc >= {1'b0, cnt_ff}) begin
               next_in = wrap_ff ? '0 : rem_ff;
            end else begin
               next_in = CW'(base_inc);
            end
            state_in = S_RDB;
         end
         S_RDB: begin
            a_in     = ram_rd_data;
            state_in = S_RDW;
         end
         S_RDW: begin
            b_in     = ram_rd_data;
            lane_in  = '0;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            diff_in = {b_ff[kts_pkg::COMP_W-1], b_ff[kts_pkg::COMP_W-1:0]} -
                      {a_ff[kts_pkg::COMP_W-1], a_ff[kts_pkg::COMP_W-1:0]};
            state_in = S_MULT;
         end
         S_MULT: begin
            state_in = S_ADD;
         end
         S_ADD: begin
            // rotate lanes so the active one is always the low word
            res_in  = {lerp_val, res_ff[kts_pkg::KEY_W-1:kts_pkg::COMP_W]};
            a_in    = {a_ff[kts_pkg::COMP_W-1:0], a_ff[kts_pkg::KEY_W-1:kts_pkg::COMP_W]};
            b_in    = {b_ff[kts_pkg::COMP_W-1:0], b_ff[kts_pkg::KEY_W-1:kts_pkg::COMP_W]};
            lane_in = lane_ff + 2'd1;
            if (lane_ff == 2'd3) begin
               state_in = S_DONE;
            end else begin
               state_in = S_DIFF;
            end
         end
         S_DONE: begin
            // wait here while an earlier response is still held
            if (out_free) begin
               rsp_data_in.value_x        = res_ff[0*kts_pkg::COMP_W +: kts_pkg::COMP_W];
               rsp_data_in.value_y        = res_ff[1*kts_pkg::COMP_W +: kts_pkg::COMP_W];
               rsp_data_in.value_z        = res_ff[2*kts_pkg::COMP_W +: kts_pkg::COMP_W];
               rsp_data_in.value_w        = res_ff[3*kts_pkg::COMP_W +: kts_pkg::COMP_W];
               rsp_data_in.base_frame     = kts_pkg::SLOT_W'(rem_ff);
               rsp_data_in.blend_fraction = frac_ff;
               rsp_valid_in               = 1'b1;
               state_in                   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         frame_count_ff <= kts_pkg::FRAME_COUNT_RST;
         frame_rate_ff  <= kts_pkg::FRAME_RATE_RST;
         wrap_enable_ff <= kts_pkg::WRAP_ENABLE_RST;
         div_cnt_ff     <= '0;
         lane_ff        <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         frame_count_ff <= frame_count_in;
         frame_rate_ff  <= frame_rate_in;
         wrap_enable_ff <= wrap_enable_in;
         div_cnt_ff     <= div_cnt_in;
         lane_ff        <= lane_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      time_ff     <= time_in;
      cnt_ff      <= cnt_in;
      wrap_ff     <= wrap_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      frac_ff     <= frac_in;
      next_ff     <= next_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      res_ff      <= res_in;
      diff_ff     <= diff_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== hdl/kts_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module kts_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

// ===== hdl/kts_mul.sv =====
// shared signed multiplier with registered product
// depends on kts_pkg for operand widths

module kts_mul (
   input  logic                                clock,
   input  logic signed [kts_pkg::MUL_A_W-1:0]  op_a,
   input  logic signed [kts_pkg::MUL_B_W-1:0]  op_b,
   output logic signed [kts_pkg::MUL_P_W-1:0]  prod_ff
);

   logic signed [kts_pkg::MUL_P_W-1:0] prod_in;

   assign prod_in = kts_pkg::MUL_P_W'(op_a) * kts_pkg::MUL_P_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule
